/* design/cebe_pkg.sv */
// cebe_pkg: shared types and constants for the c escape byte encoder
// no dependencies; used by every module of the block

package cebe_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned MapW     = 64;
    localparam int unsigned MapWords = 4;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned QDepth   = 4;
    localparam int unsigned QAddrW   = $clog2(QDepth);
    localparam int unsigned QCountW  = $clog2(QDepth + 1);

    // register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] RegDelimMap0 = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] RegDelimMap1 = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] RegDelimMap2 = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] RegDelimMap3 = CfgIdxW'(3);

    // characters
    localparam logic [ByteW-1:0] ChBackspace = 8'h08;
    localparam logic [ByteW-1:0] ChTab       = 8'h09;
    localparam logic [ByteW-1:0] ChNewline   = 8'h0A;
    localparam logic [ByteW-1:0] ChVtab      = 8'h0B;
    localparam logic [ByteW-1:0] ChFormfeed  = 8'h0C;
    localparam logic [ByteW-1:0] ChReturn    = 8'h0D;
    localparam logic [ByteW-1:0] ChSpace     = 8'h20;
    localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
    localparam logic [ByteW-1:0] ChDel       = 8'h7F;
    localparam logic [ByteW-1:0] ChZero      = 8'h30;
    localparam logic [ByteW-1:0] ChLetterB   = 8'h62;
    localparam logic [ByteW-1:0] ChLetterF   = 8'h66;
    localparam logic [ByteW-1:0] ChLetterN   = 8'h6E;
    localparam logic [ByteW-1:0] ChLetterR   = 8'h72;
    localparam logic [ByteW-1:0] ChLetterT   = 8'h74;
    localparam logic [ByteW-1:0] ChLetterV   = 8'h76;

    // how one input byte is written out
    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,  // the byte itself
        KIND_PAIR  = 2'd1,  // backslash, then data
        KIND_OCTAL = 2'd2   // backslash, then three octal digits
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [ByteW-1:0] data;
    } esc_entry_t;

    // front to queue
    typedef struct packed {
        logic       valid;
        esc_entry_t entry;
    } q_push_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic       valid;
        esc_entry_t entry;
    } q_head_t;

endpackage

/* design/cebe_front.sv */
// cebe_front: delimiter map registers, input transfer and byte classification
// depends on cebe_pkg

module cebe_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cebe_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [cebe_pkg::MapW-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cebe_pkg::ByteW-1:0]    in_byte,
    input  logic                          q_full,
    output cebe_pkg::q_push_t             q_push
);

    logic [cebe_pkg::MapW-1:0] map_reg [cebe_pkg::MapWords];
    logic [cebe_pkg::MapW-1:0] map_word;
    logic                      is_delim;
    cebe_pkg::esc_entry_t      entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cebe_pkg::MapWords; i++)
            begin
                map_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cebe_pkg::RegDelimMap0: map_reg[0] <= cfg_data;
                cebe_pkg::RegDelimMap1: map_reg[1] <= cfg_data;
                cebe_pkg::RegDelimMap2: map_reg[2] <= cfg_data;
                cebe_pkg::RegDelimMap3: map_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign map_word = map_reg[in_byte[7:6]];
    assign is_delim = map_word[in_byte[5:0]];

    // letter escapes win over the map; map wins over plain and octal
    always_comb
    begin
        entry.kind = cebe_pkg::KIND_PAIR;
        entry.data = in_byte;
        case (in_byte)
            cebe_pkg::ChBackspace: entry.data = cebe_pkg::ChLetterB;
            cebe_pkg::ChFormfeed:  entry.data = cebe_pkg::ChLetterF;
            cebe_pkg::ChNewline:   entry.data = cebe_pkg::ChLetterN;
            cebe_pkg::ChReturn:    entry.data = cebe_pkg::ChLetterR;
            cebe_pkg::ChTab:       entry.data = cebe_pkg::ChLetterT;
            cebe_pkg::ChVtab:      entry.data = cebe_pkg::ChLetterV;
            cebe_pkg::ChBackslash: entry.data = cebe_pkg::ChBackslash;
            default:
            begin
                if (is_delim)
                begin
                    entry.kind = cebe_pkg::KIND_PAIR;
                end
                else if (in_byte >= cebe_pkg::ChSpace && in_byte != cebe_pkg::ChDel)
                begin
                    entry.kind = cebe_pkg::KIND_PLAIN;
                end
                else
                begin
                    entry.kind = cebe_pkg::KIND_OCTAL;
                end
            end
        endcase
    end

    assign in_stall     = q_full;
    assign q_push.valid = in_valid && !q_full;
    assign q_push.entry = entry;

endmodule

/* design/cebe_queue.sv */
// cebe_queue: short flop-based queue of classified bytes between front and back
// depends on cebe_pkg

module cebe_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  cebe_pkg::q_push_t q_push,
    output logic              q_full,
    input  logic              q_pop,
    output cebe_pkg::q_head_t q_head
);

    cebe_pkg::esc_entry_t             slot_reg [cebe_pkg::QDepth];
    logic [cebe_pkg::QAddrW-1:0]      wr_ptr_reg;
    logic [cebe_pkg::QAddrW-1:0]      wr_ptr_next;
    logic [cebe_pkg::QAddrW-1:0]      rd_ptr_reg;
    logic [cebe_pkg::QAddrW-1:0]      rd_ptr_next;
    logic [cebe_pkg::QCountW-1:0]     count_reg;
    logic [cebe_pkg::QCountW-1:0]     count_next;
    logic                             do_push;
    logic                             do_pop;

    assign q_full       = (count_reg == cebe_pkg::QCountW'(cebe_pkg::QDepth));
    assign q_head.valid = (count_reg != '0);
    assign q_head.entry = slot_reg[rd_ptr_reg];

    assign do_push = q_push.valid && !q_full;
    assign do_pop  = q_pop && q_head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == cebe_pkg::QAddrW'(cebe_pkg::QDepth - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == cebe_pkg::QAddrW'(cebe_pkg::QDepth - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

endmodule

/* design/cebe_back.sv */
// cebe_back: steps through the escape sequence of the queue head into the output register
// depends on cebe_pkg

module cebe_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cebe_pkg::q_head_t           q_head,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [cebe_pkg::ByteW-1:0]  out_byte,
    output logic                        last
);

    logic [1:0]                 step_reg;
    logic [1:0]                 step_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [cebe_pkg::ByteW-1:0] out_byte_reg;
    logic                       last_reg;
    logic [cebe_pkg::ByteW-1:0] emit_byte;
    logic                       emit_last;
    logic                       load;
    logic [2:0]                 digit;

    // octal digit for the current step, most significant first
    always_comb
    begin
        case (step_reg)
            2'd1:    digit = {1'b0, q_head.entry.data[7:6]};
            2'd2:    digit = q_head.entry.data[5:3];
            default: digit = q_head.entry.data[2:0];
        endcase
    end

    always_comb
    begin
        emit_byte = cebe_pkg::ChBackslash;
        emit_last = 1'b0;
        case (q_head.entry.kind)
            cebe_pkg::KIND_PLAIN:
            begin
                emit_byte = q_head.entry.data;
                emit_last = 1'b1;
            end
            cebe_pkg::KIND_PAIR:
            begin
                if (step_reg != 2'd0)
                begin
                    emit_byte = q_head.entry.data;
                    emit_last = 1'b1;
                end
            end
            cebe_pkg::KIND_OCTAL:
            begin
                if (step_reg != 2'd0)
                begin
                    emit_byte = cebe_pkg::ChZero + cebe_pkg::ByteW'(digit);
                end
                emit_last = (step_reg == 2'd3);
            end
            default:
            begin
                emit_byte = q_head.entry.data;
                emit_last = 1'b1;
            end
        endcase
    end

    // output slot is free when empty or being drained this cycle
    assign load  = q_head.valid && (!out_valid_reg || !out_stall);
    assign q_pop = load && emit_last;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            step_next      = emit_last ? 2'd0 : step_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= emit_byte;
            last_reg     <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

endmodule

/* design/c_escape_byte_encoder.sv */
// c_escape_byte_encoder: an input byte is registered in a queue slot, then in the output register
// throughput is one output byte per cycle while the queue holds bytes and the output does not stall;
// an input gives 1, 2 or 4 output bytes (plain, backslash pair, octal), so the output port sets the rate
// a four-entry queue lets the input side keep taking bytes while the output stalls
// reset clears the delimiter map, the queue and the output register valid
// depends on cebe_pkg, cebe_front, cebe_queue, cebe_back

module c_escape_byte_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration writes: delimiter map words 0 to 3
    input  logic                          cfg_we,
    input  logic [cebe_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [cebe_pkg::MapW-1:0]     cfg_data,
    // input channel, one raw byte per transfer
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cebe_pkg::ByteW-1:0]    in_byte,
    // output channel, one escaped byte per transfer
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cebe_pkg::ByteW-1:0]    out_byte,
    output logic                          last
);

    cebe_pkg::q_push_t q_push;
    cebe_pkg::q_head_t q_head;
    logic              q_full;
    logic              q_pop;

    // front end: map registers and classification of each accepted byte
    cebe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .q_full    (q_full),
        .q_push    (q_push)
    );

    // queue of classified bytes, decouples the two stall domains
    cebe_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_full (q_full),
        .q_pop  (q_pop),
        .q_head (q_head)
    );

    // back end: walks the escape sequence, one byte per output transfer
    cebe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule
